// File: rtl/parallel_port_key_dongle_macros.svh
// ----------------------------------------------------------------------------
// Key dongle assertion macros
// Shared property wrappers for the dongle's port checker.
// ----------------------------------------------------------------------------
`ifndef PARALLEL_PORT_KEY_DONGLE_MACROS_SVH
`define PARALLEL_PORT_KEY_DONGLE_MACROS_SVH

// Check a property once reset has been released
`define PPKD_CHECK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check a property at every edge, reset included
`define PPKD_CHECK_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

// File: rtl/ppkd_pkg.sv
// ----------------------------------------------------------------------------
// Key dongle package
// Types, byte codes, command sets and the fixed password and product tables.
// ----------------------------------------------------------------------------
package ppkd_pkg;

	// Sizes
	localparam int PASSWORD_LEN = 14;
	localparam int PRODUCT_LEN  = 46;
	localparam int CAPTURE_LEN  = 41;
	localparam int POS_W        = 6;
	localparam int ROM_DEPTH    = 64;

	// Product index derivation from the second capture
	localparam int TAP_FIRST    = 2;
	localparam int TAP_STRIDE   = 3;
	localparam int TAP_BIT      = 6;
	localparam int TAP_COUNT    = (CAPTURE_LEN - TAP_FIRST + TAP_STRIDE - 1) / TAP_STRIDE;
	localparam int DIFF_W       = TAP_COUNT + 1;
	localparam int INDEX_SHIFT  = 4;
	localparam int IDX_W        = 17;
	localparam int IDX_MAX      = 65535;
	localparam int INDEX_BASE   = 'hc08;
	localparam int INDEX_LIMIT  = 'h38;
	localparam int PRODUCT_BITS = PRODUCT_LEN * 8;

	// Byte codes
	localparam logic [7:0]  UNLOCK_A      = 8'hc6;
	localparam logic [7:0]  UNLOCK_B      = 8'hc7;
	localparam logic [7:0]  UNLOCK_END    = 8'h80;
	localparam logic [7:0]  CMD_SELECT    = 8'h9d;
	localparam logic [7:0]  HDR_FIRST     = 8'h9c;
	localparam logic [7:0]  HDR_SECOND    = 8'h9e;
	localparam logic [7:0]  STATUS_RESET  = 8'h80;
	localparam logic [7:0]  STATUS_ANSWER = 8'h20;
	localparam logic [15:0] PATTERN_KEY   = 16'h534d;

	// Access kinds
	localparam logic ACCESS_WRITE = 1'b0;
	localparam logic ACCESS_READ  = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PASS  = 2'd1,
		PH_AFTER = 2'd2,
		PH_READ  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KM_NONE = 2'd0,
		KM_PASS = 2'd1,
		KM_CMD  = 2'd2,
		KM_PROD = 2'd3
	} key_mode_t;

	typedef enum logic [1:0] {
		UL_IDLE = 2'd0,
		UL_A    = 2'd1,
		UL_B    = 2'd2,
		UL_C    = 2'd3
	} unlock_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic  fire;
		item_t item;
	} step_t;

	localparam logic [7:0] PASSWORD_ROM [ROM_DEPTH] = '{
		8'hc3, 8'hd9, 8'hd3, 8'hfb, 8'h9d, 8'h89, 8'hb9, 8'ha1,
		8'hb3, 8'hc1, 8'hf1, 8'hcd, 8'hdf, 8'h9d, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam logic [7:0] PRODUCT_ROM [ROM_DEPTH] = '{
		8'h51, 8'h4c, 8'h52, 8'h4d, 8'h53, 8'h4e, 8'h53, 8'h4e,
		8'h53, 8'h49, 8'h53, 8'h48, 8'h53, 8'h4b, 8'h53, 8'h4a,
		8'h53, 8'h43, 8'h53, 8'h45, 8'h52, 8'h46, 8'h53, 8'h43,
		8'h53, 8'h41, 8'hac, 8'h40, 8'h53, 8'hbc, 8'h53, 8'h42,
		8'h53, 8'h57, 8'h53, 8'h5d, 8'h52, 8'h5e, 8'h53, 8'h5b,
		8'h53, 8'h59, 8'hac, 8'h58, 8'h53, 8'ha4, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// Commands swallowed without an answer in command mode
	function automatic logic mode2_silent(logic [7:0] v);
		logic hit;
		unique case (v)
			8'h94, 8'h9e, 8'ha4, 8'hb2, 8'hbe, 8'hd0: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// Commands answered in command mode only
	function automatic logic mode2_answer(logic [7:0] v);
		logic hit;
		unique case (v)
			8'h8a, 8'h8e, 8'hca, 8'hd2, 8'he2, 8'hf0, 8'hfc: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// Commands answered in every read mode, but for those swallowed in command mode
	function automatic logic general_answer(logic [7:0] v);
		logic hit;
		unique case (v)
			8'h88,
			8'h94, 8'h98, 8'h9c, 8'h9e,
			8'ha0, 8'ha4, 8'haa, 8'hae,
			8'hb0, 8'hb2, 8'hbc, 8'hbe,
			8'hc2, 8'hc6, 8'hc8, 8'hce,
			8'hd0, 8'hd6, 8'hd8, 8'hdc,
			8'he0, 8'he6, 8'hea, 8'hee,
			8'hf2, 8'hf6: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// Capture positions whose bit feeds the product index
	function automatic logic is_tap(logic [POS_W-1:0] pos);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < TAP_COUNT; k++) begin
			if (pos == POS_W'(TAP_FIRST + k * TAP_STRIDE))
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

// File: rtl/ppkd_ifs.sv
// ----------------------------------------------------------------------------
// Key dongle channels
// Valid/ready channels for access items and status results.
// ----------------------------------------------------------------------------
interface ppkd_req_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface ppkd_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] status;

	modport source (output valid, output status, input ready);
	modport sink (input valid, input status, output ready);
endinterface

// File: rtl/ppkd_core.sv
// ----------------------------------------------------------------------------
// Key dongle core
// Unlock detector, password check, index capture and answer logic; all
// state moves by one access per cycle, and only when an access fires.
// ----------------------------------------------------------------------------
module ppkd_core (
	input  logic            clk,
	input  logic            arst_n,
	input  ppkd_pkg::step_t step,
	output logic [7:0]      status
);
	import ppkd_pkg::*;

	unlock_t                 unlock_q, unlock_d;
	phase_t                  phase_q, phase_d;
	phase_t                  ph;
	key_mode_t               km_q, km_d;
	logic [POS_W-1:0]        pos_q, pos_d, pos_inc;
	logic signed [IDX_W-1:0] idx_q, idx_d, idx_sat;
	logic [7:0]              status_q, status_d;
	logic                    match_q, match_d, match_next;
	logic                    hdr_q, hdr_d, hdr_next;
	logic [TAP_COUNT-1:0]    acc_q, acc_d, acc_next;
	logic [7:0]              v;
	logic                    reopen;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W+INDEX_SHIFT-1:0] idx_wide;
	logic                    key_sel;
	logic [15:0]             up, upm1, word;
	logic [7:0]              rom_byte;
	logic [2:0]              rsh;
	logic [3:0]              psh;
	logic                    read_bit;

	assign v = step.item.data_byte;

	// Advance the capture position, holding at the top
	assign pos_inc = (pos_q == '1) ? pos_q : pos_q + POS_W'(1);

	// Running password compare
	always_comb begin
		if (pos_q == '0)
			match_next = (v == PASSWORD_ROM[pos_q]);
		else
			match_next = match_q & (v == PASSWORD_ROM[pos_q]);
	end

	// Header check and index bit collection for the second capture
	always_comb begin
		if (pos_q == '0)
			hdr_next = (v == HDR_FIRST);
		else if (pos_q == POS_W'(1))
			hdr_next = hdr_q & (v == HDR_SECOND);
		else
			hdr_next = hdr_q;

		if (pos_q == '0)
			acc_next = '0;
		else if (is_tap(pos_q))
			acc_next = {acc_q[TAP_COUNT-2:0], v[TAP_BIT]};
		else
			acc_next = acc_q;
	end

	// Derive the product bit index, saturated
	always_comb begin
		diff     = $signed({1'b0, acc_next}) - $signed(DIFF_W'(INDEX_BASE));
		idx_wide = {diff, {INDEX_SHIFT{1'b0}}};
		key_sel  = diff < $signed(DIFF_W'(INDEX_LIMIT));
		if (idx_wide > $signed((DIFF_W+INDEX_SHIFT)'(IDX_MAX)))
			idx_sat = IDX_W'(IDX_MAX);
		else
			idx_sat = idx_wide[IDX_W-1:0];
	end

	// Pick the answer bit for a status read
	always_comb begin
		up       = idx_q[15:0];
		upm1     = up - 16'd1;
		rom_byte = PRODUCT_ROM[upm1[8:3]];
		rsh      = 3'd0 - up[2:0];
		psh      = 4'd0 - up[3:0];
		word     = PATTERN_KEY ^ (upm1 >> 4);
		if (idx_q[IDX_W-1] || idx_q == '0)
			read_bit = 1'b0;
		else if (idx_q <= $signed(IDX_W'(PRODUCT_BITS)))
			read_bit = rom_byte[rsh];
		else
			read_bit = word[psh];
	end

	// Next state for one access
	always_comb begin
		unlock_d = unlock_q;
		phase_d  = phase_q;
		km_d     = km_q;
		pos_d    = pos_q;
		idx_d    = idx_q;
		status_d = status_q;
		match_d  = match_q;
		hdr_d    = hdr_q;
		acc_d    = acc_q;
		ph       = phase_q;
		reopen   = 1'b0;

		if (step.fire) begin
			if (step.item.mode == ACCESS_WRITE) begin
				unique case (unlock_q)
					UL_IDLE: unlock_d = (v == UNLOCK_A) ? UL_A : UL_IDLE;
					UL_A:    unlock_d = (v == UNLOCK_B) ? UL_B : UL_IDLE;
					UL_B: begin
						if (v == UNLOCK_A) begin
							unlock_d = UL_C;
						end else begin
							unlock_d = UL_IDLE;
							ph       = PH_IDLE;
						end
					end
					UL_C: begin
						unlock_d = UL_IDLE;
						reopen   = (v == UNLOCK_END);
					end
				endcase
				phase_d = ph;

				if (reopen) begin
					// Unlock complete: open the password capture, status stays
					phase_d = PH_PASS;
					pos_d   = '0;
				end else begin
					status_d = '0;
					unique case (ph)
						PH_READ: begin
							priority if (km_q == KM_CMD && mode2_silent(v))
								status_d = '0;
							else if (km_q == KM_CMD && mode2_answer(v))
								status_d = STATUS_ANSWER;
							else if (general_answer(v))
								status_d = STATUS_ANSWER;
							else
								status_d = '0;
						end
						PH_AFTER: begin
							if (v[0]) begin
								if (km_q == KM_PASS && v == CMD_SELECT)
									km_d = KM_CMD;
								phase_d = PH_READ;
							end else if (km_q == KM_PASS) begin
								pos_d = pos_inc;
								hdr_d = hdr_next;
								acc_d = acc_next;
								if (pos_inc == POS_W'(CAPTURE_LEN)) begin
									phase_d = PH_READ;
									if (hdr_next) begin
										idx_d = idx_sat;
										if (key_sel)
											km_d = KM_PROD;
									end
								end
							end
						end
						PH_PASS: begin
							if (v[0]) begin
								pos_d   = pos_inc;
								match_d = match_next;
								if (pos_inc == POS_W'(PASSWORD_LEN)) begin
									phase_d = PH_AFTER;
									pos_d   = '0;
									km_d    = match_next ? KM_PASS : KM_NONE;
								end
							end
						end
						PH_IDLE: begin
						end
					endcase
				end
			end else begin
				// Status read: product bits in the product mode only
				if (phase_q == PH_READ && km_q == KM_PROD) begin
					status_d = {2'b00, read_bit, 5'b00000};
					if (idx_q != IDX_W'(IDX_MAX))
						idx_d = idx_q + IDX_W'(1);
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unlock_q <= UL_IDLE;
			phase_q  <= PH_IDLE;
			km_q     <= KM_NONE;
			pos_q    <= '0;
			idx_q    <= '0;
			status_q <= STATUS_RESET;
			match_q  <= 1'b0;
			hdr_q    <= 1'b0;
			acc_q    <= '0;
		end else begin
			unlock_q <= unlock_d;
			phase_q  <= phase_d;
			km_q     <= km_d;
			pos_q    <= pos_d;
			idx_q    <= idx_d;
			status_q <= status_d;
			match_q  <= match_d;
			hdr_q    <= hdr_d;
			acc_q    <= acc_d;
		end
	end

	assign status = status_d;

endmodule

// File: rtl/parallel_port_key_dongle.sv
// ----------------------------------------------------------------------------
// Parallel port key dongle
// Access items in, one status result out per item.
// ----------------------------------------------------------------------------
// Each accepted item is one port access: a data write or a status read. It is
// held in an input register and decided by the core when the result register
// is free; its status byte then lands in the result register, which offers it.
// A new item can be taken every cycle while results are taken as offered; the
// limit is the state update in the core, which every access reads and writes.
// While a result waits to be taken, one more item is still accepted into the
// input register. No memory is used: the capture is reduced to a running
// compare, so there is no clearing pass.
module parallel_port_key_dongle (
	input logic        clk,
	input logic        arst_n,
	ppkd_req_if.sink   req,
	ppkd_rsp_if.source rsp
);
	import ppkd_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	logic       advance;
	step_t      step;
	logic [7:0] status_d;
	logic       valid_s2;
	logic [7:0] status_s2;

	// Move the held item on when the result register is free
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.mode      <= req.mode;
			item_s1.data_byte <= req.data_byte;
		end
	end

	assign step.fire = advance;
	assign step.item = item_s1;

	ppkd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.status (status_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			status_s2 <= status_d;
	end

	assign rsp.valid  = valid_s2;
	assign rsp.status = status_s2;

endmodule

// File: rtl/ppkd_checker.sv
// ----------------------------------------------------------------------------
// Key dongle port checker
// Watches the channels of the dongle and checks item flow and result codes.
// ----------------------------------------------------------------------------
`include "parallel_port_key_dongle_macros.svh"

module ppkd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_status
);
	import ppkd_pkg::*;

	logic [1:0] pend_q;
	logic       req_take;
	logic       rsp_take;
	logic       status_ok;

	assign req_take = req_valid && req_ready;
	assign rsp_take = rsp_valid && rsp_ready;

	// Only a cleared status, an answer or the reset value can come out
	assign status_ok = (rsp_status == 8'h00) || (rsp_status == STATUS_ANSWER) ||
		(rsp_status == STATUS_RESET);

	// Count items taken in but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + 2'(req_take) - 2'(rsp_take);
	end

	`PPKD_CHECK_ALWAYS(a_pend_bound, pend_q <= 2'd2, "more than two items in flight")
	`PPKD_CHECK(a_no_invented, rsp_valid |-> pend_q != 2'd0, "result without an item")
	`PPKD_CHECK(a_prompt, !rsp_valid && pend_q != 2'd0 |=> rsp_valid, "held item not answered")
	`PPKD_CHECK(a_status_code, rsp_valid |-> status_ok, "bad status code")
	`PPKD_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status), "stalled result changed")

endmodule

bind parallel_port_key_dongle ppkd_checker u_ppkd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status)
);

// File: tb/sv/ppkd_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key dongle status checker
// Watches both channels, keeps its own copy of the dongle state, works out the
// status byte of every accepted access and compares each result, in order,
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ppkd_status_checker (
	input  logic        clk,
	input  logic        arst_n,
	ppkd_req_if         req,
	ppkd_rsp_if         rsp,
	output int unsigned fail_count,
	output int unsigned pending
);
	import ppkd_pkg::*;

	localparam int REPORT_MAX = 10;

	// Product index derivation
	localparam int          TAP0        = 2;
	localparam int          TAP_GAP     = 3;
	localparam int          TAP_SEL     = 6;
	localparam int          IDX_OFFSET  = 'hc08;
	localparam int          MODE3_LIMIT = 'h38;
	localparam int          IDX_CEIL    = 65535;
	localparam logic [15:0] PAT_KEY     = 16'h534d;

	localparam logic [7:0] KEY_BYTES [PASSWORD_LEN] = '{
		8'hc3, 8'hd9, 8'hd3, 8'hfb, 8'h9d, 8'h89, 8'hb9,
		8'ha1, 8'hb3, 8'hc1, 8'hf1, 8'hcd, 8'hdf, 8'h9d
	};

	localparam logic [7:0] PRODUCT_TAB [PRODUCT_LEN] = '{
		8'h51, 8'h4c, 8'h52, 8'h4d, 8'h53, 8'h4e, 8'h53, 8'h4e,
		8'h53, 8'h49, 8'h53, 8'h48, 8'h53, 8'h4b, 8'h53, 8'h4a,
		8'h53, 8'h43, 8'h53, 8'h45, 8'h52, 8'h46, 8'h53, 8'h43,
		8'h53, 8'h41, 8'hac, 8'h40, 8'h53, 8'hbc, 8'h53, 8'h42,
		8'h53, 8'h57, 8'h53, 8'h5d, 8'h52, 8'h5e, 8'h53, 8'h5b,
		8'h53, 8'h59, 8'hac, 8'h58, 8'h53, 8'ha4
	};

	// Predicted dongle state
	unlock_t                 ul_step;
	phase_t                  dg_phase;
	key_mode_t               dg_mode;
	logic [POS_W-1:0]        cap_pos;
	logic signed [IDX_W-1:0] bit_idx;
	logic [7:0]              st_reg;
	logic [7:0]              cap_mem [CAPTURE_LEN];

	logic [7:0]  expected_status [$];
	int unsigned status_errors;

	// Commands swallowed silently in command mode
	function automatic logic cmd_swallowed(input logic [7:0] v);
		case (v)
			8'h94, 8'h9e, 8'ha4, 8'hb2, 8'hbe, 8'hd0: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Commands that only command mode answers
	function automatic logic cmd_extra_answer(input logic [7:0] v);
		case (v)
			8'h8a, 8'h8e, 8'hca, 8'hd2, 8'he2, 8'hf0, 8'hfc: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Commands answered in any read phase, but for those swallowed in command mode
	function automatic logic cmd_answered(input logic [7:0] v);
		case (v)
			8'h88, 8'h94, 8'h98, 8'h9c, 8'h9e, 8'ha0, 8'ha4, 8'haa, 8'hae,
			8'hb0, 8'hb2, 8'hbc, 8'hbe, 8'hc2, 8'hc6, 8'hc8, 8'hce, 8'hd0,
			8'hd6, 8'hd8, 8'hdc, 8'he0, 8'he6, 8'hea, 8'hee, 8'hf2, 8'hf6: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic key_matches();
		for (int i = 0; i < PASSWORD_LEN; i++) begin
			if (cap_mem[i] != KEY_BYTES[i])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic reset_model();
		ul_step  = UL_IDLE;
		dg_phase = PH_IDLE;
		dg_mode  = KM_NONE;
		cap_pos  = '0;
		bit_idx  = '0;
		st_reg   = STATUS_RESET;
		for (int i = 0; i < CAPTURE_LEN; i++)
			cap_mem[i] = 8'h00;
	endtask

	// Store one captured byte and advance, holding at the top position
	task automatic store_byte(input logic [7:0] v);
		if (cap_pos < CAPTURE_LEN)
			cap_mem[cap_pos] = v;
		if (cap_pos != {POS_W{1'b1}})
			cap_pos = cap_pos + 1'b1;
	endtask

	// Build the product index from the tap bits of the second capture
	task automatic derive_index();
		int acc;
		int idx;
		if (cap_mem[0] != HDR_FIRST || cap_mem[1] != HDR_SECOND)
			return;
		acc = 0;
		for (int i = TAP0; i < CAPTURE_LEN; i += TAP_GAP)
			acc = acc * 2 + int'(cap_mem[i][TAP_SEL]);
		idx = (acc - IDX_OFFSET) * 16;
		bit_idx = (idx > IDX_CEIL) ? IDX_W'(IDX_CEIL) : IDX_W'(idx);
		if (idx < MODE3_LIMIT * 16)
			dg_mode = KM_PROD;
	endtask

	task automatic apply_write(input logic [7:0] v);
		// Track the unlock sequence; its last byte restarts the key capture
		case (ul_step)
			UL_IDLE: ul_step = (v == UNLOCK_A) ? UL_A : UL_IDLE;
			UL_A:    ul_step = (v == UNLOCK_B) ? UL_B : UL_IDLE;
			UL_B: begin
				if (v == UNLOCK_A) begin
					ul_step = UL_C;
				end else begin
					ul_step  = UL_IDLE;
					dg_phase = PH_IDLE;
				end
			end
			default: begin
				ul_step = UL_IDLE;
				if (v == UNLOCK_END) begin
					dg_phase = PH_PASS;
					cap_pos  = '0;
					return;
				end
			end
		endcase

		st_reg = 8'h00;
		case (dg_phase)
			PH_READ: begin
				if (dg_mode == KM_CMD) begin
					if (cmd_swallowed(v))
						return;
					if (cmd_extra_answer(v)) begin
						st_reg = STATUS_ANSWER;
						return;
					end
				end
				if (cmd_answered(v))
					st_reg = STATUS_ANSWER;
			end
			PH_AFTER: begin
				if (v[0]) begin
					if (dg_mode == KM_PASS && v == CMD_SELECT)
						dg_mode = KM_CMD;
					dg_phase = PH_READ;
				end else if (dg_mode == KM_PASS) begin
					store_byte(v);
					if (cap_pos == CAPTURE_LEN) begin
						derive_index();
						dg_phase = PH_READ;
					end
				end
			end
			PH_PASS: begin
				if (v[0]) begin
					store_byte(v);
					if (cap_pos == PASSWORD_LEN) begin
						dg_phase = PH_AFTER;
						cap_pos  = '0;
						dg_mode  = key_matches() ? KM_PASS : KM_NONE;
					end
				end
			end
			default: ;
		endcase
	endtask

	// Product mode read: next table bit, then the keyed pattern
	task automatic apply_read();
		int          p;
		logic        b;
		logic [15:0] word;
		if (dg_phase != PH_READ || dg_mode != KM_PROD)
			return;
		p = bit_idx;
		if (p <= 0) begin
			b = 1'b0;
		end else if (p <= PRODUCT_LEN * 8) begin
			b = PRODUCT_TAB[(p - 1) / 8][7 - (p - 1) % 8];
		end else begin
			word = PAT_KEY ^ 16'((p - 1) / 16);
			b    = word[15 - (p - 1) % 16];
		end
		st_reg = b ? STATUS_ANSWER : 8'h00;
		if (bit_idx < IDX_CEIL)
			bit_idx = bit_idx + IDX_W'(1);
	endtask

	task automatic predict_status(input logic m, input logic [7:0] v, output logic [7:0] st);
		if (m == ACCESS_READ)
			apply_read();
		else
			apply_write(v);
		st = st_reg;
	endtask

	task automatic log_failure(input string what, input logic [7:0] want,
			input logic [7:0] got);
		status_errors++;
		if (status_errors <= REPORT_MAX)
			$display("[%0t] %s: expected status %02h, got %02h", $time, what, want, got);
	endtask

	// Retire results first, then predict the item taken at the same edge
	always @(posedge clk or negedge arst_n) begin : watch
		logic [7:0] want;
		if (!arst_n) begin
			reset_model();
			expected_status.delete();
			status_errors = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_status.size() == 0) begin
					log_failure("result with nothing outstanding", 8'hxx, rsp.status);
				end else begin
					want = expected_status.pop_front();
					if (rsp.status !== want)
						log_failure("status mismatch", want, rsp.status);
				end
			end
			if (req.valid && req.ready) begin
				predict_status(req.mode, req.data_byte, want);
				expected_status.push_back(want);
			end
		end
		fail_count <= status_errors;
		pending    <= expected_status.size();
	end

endmodule

// File: tb/sv/tb_parallel_port_key_dongle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key dongle testbench
// Drives unlock, key and product capture sessions with random content and
// noise, idles both channels at random and stalls the result side for a long
// stretch. The checker beside the block predicts and compares; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module tb_parallel_port_key_dongle;
	import ppkd_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	localparam int IDLE_PCT     = 18;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 12;

	// Capture seeds: the index is (seed - base) * 16
	localparam int unsigned SEED_ZERO = INDEX_BASE;
	localparam int unsigned SEED_TOP  = INDEX_BASE + INDEX_LIMIT - 1;
	localparam int unsigned SEED_MAX  = (1 << TAP_COUNT) - 1;

	localparam int CMD_COUNT = 34;
	localparam logic [7:0] CMD_POOL [CMD_COUNT] = '{
		8'h88, 8'h94, 8'h98, 8'h9c, 8'h9e, 8'ha0, 8'ha4, 8'haa, 8'hae,
		8'hb0, 8'hb2, 8'hbc, 8'hbe, 8'hc2, 8'hc6, 8'hc8, 8'hce, 8'hd0,
		8'hd6, 8'hd8, 8'hdc, 8'he0, 8'he6, 8'hea, 8'hee, 8'hf2, 8'hf6,
		8'h8a, 8'h8e, 8'hca, 8'hd2, 8'he2, 8'hf0, 8'hfc
	};

	typedef enum int {
		SESS_SELECT,
		SESS_PLAIN,
		SESS_WRONG_KEY,
		SESS_PRODUCT,
		SESS_BAD_HDR,
		SESS_HIGH_INDEX,
		SESS_BROKEN,
		SESS_NOISE
	} session_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        calm;
	logic        hold_ask;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned items_sent;

	ppkd_req_if req_ch ();
	ppkd_rsp_if rsp_ch ();

	parallel_port_key_dongle uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ppkd_status_checker status_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin : reset_gen
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Offer one item, idling first at random, and hold it until taken
	task automatic send_access(input logic m, input logic [7:0] b);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.mode      <= m;
		req_ch.data_byte <= b;
		do begin
			@(posedge clk);
		end while (req_ch.ready !== 1'b1);
		items_sent++;
	endtask

	task automatic send_write(input logic [7:0] b);
		send_access(ACCESS_WRITE, b);
	endtask

	task automatic send_read();
		send_access(ACCESS_READ, 8'($urandom));
	endtask

	task automatic unlock_key();
		send_write(UNLOCK_A);
		send_write(UNLOCK_B);
		send_write(UNLOCK_A);
		send_write(UNLOCK_END);
	endtask

	// Key bytes are odd; scatter ignored even bytes and reads among them
	task automatic enter_password(input bit good, input int count);
		logic [7:0] b;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 15)
				send_write(8'($urandom) & 8'hfe);
			else if ($urandom_range(99) < 5)
				send_read();
			b = good ? PASSWORD_ROM[i] : (8'($urandom) | 8'h01);
			send_write(b);
		end
	endtask

	// Even capture bytes with the seed spread over the tap positions
	task automatic capture_product(input int unsigned seed, input bit hdr_ok);
		logic [7:0] b;
		for (int i = 0; i < CAPTURE_LEN; i++) begin
			b = 8'($urandom) & 8'hfe;
			if (i == 0 && hdr_ok)
				b = HDR_FIRST;
			else if (i == 1 && hdr_ok)
				b = HDR_SECOND;
			else if (i >= TAP_FIRST && (i - TAP_FIRST) % TAP_STRIDE == 0)
				b[TAP_BIT] = seed[TAP_COUNT - 1 - (i - TAP_FIRST) / TAP_STRIDE];
			if ($urandom_range(99) < 8)
				send_read();
			send_write(b);
		end
	endtask

	task automatic read_mix(input int n, input int read_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < read_pct)
				send_read();
			else if ($urandom_range(99) < 70)
				send_write(CMD_POOL[$urandom_range(CMD_COUNT - 1)]);
			else
				send_write(8'($urandom));
		end
	endtask

	task automatic run_session(input session_t kind, input int unsigned seed);
		logic [7:0] b;
		case (kind)
			SESS_SELECT: begin
				unlock_key();
				enter_password(1'b1, PASSWORD_LEN);
				send_write(CMD_SELECT);
				read_mix(40, 30);
			end
			SESS_PLAIN: begin
				unlock_key();
				enter_password(1'b1, PASSWORD_LEN);
				b = 8'($urandom) | 8'h01;
				if (b == CMD_SELECT)
					b = 8'hff;
				send_write(b);
				read_mix(30, 40);
			end
			SESS_WRONG_KEY: begin
				unlock_key();
				enter_password(1'b0, PASSWORD_LEN);
				// even bytes are dropped without a good key
				send_write(8'($urandom) & 8'hfe);
				send_write(8'($urandom) | 8'h01);
				read_mix(30, 40);
			end
			SESS_PRODUCT, SESS_HIGH_INDEX: begin
				unlock_key();
				enter_password(1'b1, PASSWORD_LEN);
				capture_product(seed, 1'b1);
				read_mix($urandom_range(100, 20), 75);
			end
			SESS_BAD_HDR: begin
				unlock_key();
				enter_password(1'b1, PASSWORD_LEN);
				capture_product(seed, 1'b0);
				read_mix(20, 60);
			end
			SESS_BROKEN: begin
				// cut the key short, then break a fresh unlock at its third byte
				unlock_key();
				enter_password(1'b1, $urandom_range(PASSWORD_LEN - 1));
				send_write(UNLOCK_A);
				send_write(UNLOCK_B);
				b = 8'($urandom);
				if (b == UNLOCK_A)
					b = 8'h00;
				send_write(b);
				read_mix(10, 50);
			end
			default: read_mix(20, 50);
		endcase
	endtask

	function automatic int unsigned pick_seed();
		int unsigned r;
		r = $urandom_range(9);
		if (r < 5)
			return $urandom_range(SEED_TOP, SEED_ZERO);
		if (r < 8)
			return $urandom_range(SEED_ZERO - 1, SEED_ZERO - 80);
		return $urandom_range(SEED_MAX);
	endfunction

	function automatic session_t pick_session();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 40) return SESS_PRODUCT;
		if (r < 55) return SESS_SELECT;
		if (r < 63) return SESS_PLAIN;
		if (r < 71) return SESS_WRONG_KEY;
		if (r < 78) return SESS_BAD_HDR;
		if (r < 85) return SESS_HIGH_INDEX;
		if (r < 93) return SESS_BROKEN;
		return SESS_NOISE;
	endfunction

	// Result side: random idling, one long hold-off on request
	initial begin : result_sink
		int unsigned held;
		bit          hold_used;
		held      = 0;
		hold_used = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (held != 0) begin
				rsp_ch.ready <= 1'b0;
				held--;
			end else if (hold_ask && !hold_used) begin
				hold_used = 1'b1;
				held      = HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// End the run once nothing has been accepted for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		int unsigned sessions;
		session_t    kind;
		req_ch.valid     <= 1'b0;
		req_ch.mode      <= ACCESS_WRITE;
		req_ch.data_byte <= 8'h00;
		calm             <= 1'b0;
		hold_ask         <= 1'b0;
		items_sent = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Reset status, plain writes, unlock broken at its third byte, bare unlock
		send_read();
		send_write(8'h00);
		send_write(8'hff);
		send_read();
		send_write(UNLOCK_A);
		send_write(UNLOCK_B);
		send_write(8'h11);
		send_read();
		unlock_key();
		send_read();

		// One pass over every session kind and the index regions
		run_session(SESS_SELECT, 0);
		run_session(SESS_PLAIN, 0);
		run_session(SESS_WRONG_KEY, 0);
		run_session(SESS_PRODUCT, 0);
		run_session(SESS_PRODUCT, SEED_ZERO);
		run_session(SESS_PRODUCT, SEED_TOP);
		run_session(SESS_BAD_HDR, SEED_ZERO);
		run_session(SESS_HIGH_INDEX, SEED_MAX);
		run_session(SESS_BROKEN, 0);
		run_session(SESS_NOISE, 0);

		// Random sessions; one calm stretch and one long result hold-off
		sessions = 0;
		while (items_sent < RANDOM_ITEMS) begin
			calm <= (sessions >= 3 && sessions < 7);
			if (sessions == 1)
				hold_ask <= 1'b1;
			kind = pick_session();
			if (kind == SESS_HIGH_INDEX)
				run_session(kind, $urandom_range(SEED_MAX, SEED_TOP + 1));
			else
				run_session(kind, pick_seed());
			sessions++;
		end
		calm <= 1'b0;

		req_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
